@@ design/sha_pkg.sv @@
package sha_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_FOLD  = 6'b001000,
		ST_PAD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	localparam int BLK_WORDS = 16;
	localparam int ROUNDS    = 64;
	localparam int DIG_WORDS = 8;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam word_t IV [DIG_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_s0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_s1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_s0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_s1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic word_t major(input word_t a, input word_t b, input word_t c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

@@ design/sha256_message_hasher_top.sv @@
// Throughput: one byte item per cycle while a block fills; no new item is accepted while a
// full 64-byte block is compressed (block memory read into the schedule, 64 rounds, a fold),
// since every block goes through the single shared round unit.
// Final item: padding feeds the same byte path (9 to 72 pad bytes, one per cycle,
// each block compressed as above), then eight digest items, one per cycle when accepted.
// Reset (arst_n low): hash registers return to the initial hash, counters clear, idle.
module sha256_message_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] has_byte
	input  logic        s_axis_tlast,   // is_final
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic        m_axis_tlast    // digest_last
);

	sha_pkg::state_t state_q, ret_q;

	logic [5:0]        fill_q;
	logic [60:0]       msg_q;
	logic              first_q, extra_q;
	logic [4:0]        ld_cnt_q;
	logic [5:0]        rnd_q;
	logic [2:0]        out_idx_q;
	sha_pkg::word_t    h_q [sha_pkg::DIG_WORDS];
	sha_pkg::word_t    v_q [sha_pkg::DIG_WORDS];
	sha_pkg::word_t    w_q [sha_pkg::BLK_WORDS];
	logic [23:0]       word_q;

	sha_pkg::word_t    blk_mem [sha_pkg::BLK_WORDS];
	sha_pkg::word_t    rd_q;

	logic              s_acc, m_acc;
	logic              len_sel, put_en, blk_full;
	logic [7:0]        put_byte;
	logic [63:0]       bitlen;
	logic [2:0]        len_idx;
	sha_pkg::word_t    t1, t2, w_new;

	always_comb begin
		s_axis_tready = (state_q == sha_pkg::ST_IDLE);
		m_axis_tvalid = (state_q == sha_pkg::ST_OUT);
		m_axis_tdata  = h_q[out_idx_q];
		m_axis_tlast  = (out_idx_q == 3'(sha_pkg::DIG_WORDS - 1));
		s_acc = s_axis_tvalid & s_axis_tready;
		m_acc = m_axis_tvalid & m_axis_tready;

		bitlen  = {msg_q, 3'b000};
		len_idx = ~fill_q[2:0];
		// length goes in the last 8 bytes, unless the 0x80 spilled past byte 55
		len_sel = (state_q == sha_pkg::ST_PAD) & ~first_q & (fill_q[5:3] == 3'b111) & ~extra_q;

		put_en   = 1'b0;
		put_byte = s_axis_tdata;
		if (state_q == sha_pkg::ST_IDLE) begin
			put_en = s_acc & s_axis_tuser;
		end else if (state_q == sha_pkg::ST_PAD) begin
			put_en = 1'b1;
			if (first_q) begin
				put_byte = sha_pkg::PAD_BYTE;
			end else if (len_sel) begin
				put_byte = bitlen[{len_idx, 3'b000} +: 8];
			end else begin
				put_byte = 8'h00;
			end
		end
		blk_full = put_en & (fill_q == 6'h3f);

		t1 = v_q[7] + sha_pkg::big_s1(v_q[4]) + sha_pkg::choose(v_q[4], v_q[5], v_q[6])
			+ sha_pkg::K[rnd_q] + w_q[0];
		t2 = sha_pkg::big_s0(v_q[0]) + sha_pkg::major(v_q[0], v_q[1], v_q[2]);
		w_new = sha_pkg::small_s1(w_q[14]) + w_q[9] + sha_pkg::small_s0(w_q[1]) + w_q[0];
	end

	// block memory: whole words written as the fourth byte lands, one read per cycle
	always_ff @(posedge clk) begin
		if (put_en && fill_q[1:0] == 2'b11) begin
			blk_mem[fill_q[5:2]] <= {word_q, put_byte};
		end
		rd_q <= blk_mem[ld_cnt_q[3:0]];
	end

	always_ff @(posedge clk) begin
		if (put_en) begin
			word_q <= {word_q[15:0], put_byte};
		end
		if (state_q == sha_pkg::ST_LOAD) begin
			v_q <= h_q;
			if (ld_cnt_q != 5'd0) begin
				for (int i = 0; i < sha_pkg::BLK_WORDS - 1; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[sha_pkg::BLK_WORDS - 1] <= rd_q;
			end
		end else if (state_q == sha_pkg::ST_ROUND) begin
			for (int i = 0; i < sha_pkg::BLK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[sha_pkg::BLK_WORDS - 1] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sha_pkg::ST_IDLE;
			ret_q     <= sha_pkg::ST_IDLE;
			fill_q    <= '0;
			msg_q     <= '0;
			first_q   <= 1'b0;
			extra_q   <= 1'b0;
			ld_cnt_q  <= '0;
			rnd_q     <= '0;
			out_idx_q <= '0;
			h_q       <= sha_pkg::IV;
		end else begin
			if (put_en) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				sha_pkg::ST_IDLE: begin
					if (s_acc) begin
						if (s_axis_tuser) begin
							msg_q <= msg_q + 61'd1;
						end
						if (s_axis_tlast) begin
							first_q <= 1'b1;
						end
						if (blk_full) begin
							state_q <= sha_pkg::ST_LOAD;
							ret_q   <= s_axis_tlast ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
						end else if (s_axis_tlast) begin
							state_q <= sha_pkg::ST_PAD;
						end
					end
				end
				sha_pkg::ST_PAD: begin
					first_q <= 1'b0;
					if (blk_full) begin
						extra_q <= 1'b0;
						state_q <= sha_pkg::ST_LOAD;
						ret_q   <= len_sel ? sha_pkg::ST_OUT : sha_pkg::ST_PAD;
					end else if (first_q && fill_q[5:3] == 3'b111) begin
						extra_q <= 1'b1;
					end
				end
				sha_pkg::ST_LOAD: begin
					if (ld_cnt_q == 5'(sha_pkg::BLK_WORDS)) begin
						ld_cnt_q <= '0;
						rnd_q    <= '0;
						state_q  <= sha_pkg::ST_ROUND;
					end else begin
						ld_cnt_q <= ld_cnt_q + 5'd1;
					end
				end
				sha_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(sha_pkg::ROUNDS - 1)) begin
						state_q <= sha_pkg::ST_FOLD;
					end
				end
				sha_pkg::ST_FOLD: begin
					for (int i = 0; i < sha_pkg::DIG_WORDS; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					state_q <= ret_q;
				end
				sha_pkg::ST_OUT: begin
					if (m_acc) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (m_axis_tlast) begin
							h_q     <= sha_pkg::IV;
							msg_q   <= '0;
							state_q <= sha_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= sha_pkg::ST_IDLE;
				end
			endcase
		end
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input and output open together");

	a_round_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_ROUND) |-> (fill_q == 6'd0))
		else $error("compressing a partial block");

	a_out_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_OUT) |-> (!extra_q && fill_q == 6'd0))
		else $error("digest out with padding left over");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && m_axis_tlast) |=>
		(state_q == sha_pkg::ST_IDLE && msg_q == 61'd0 && h_q[0] == sha_pkg::IV[0]))
		else $error("hasher not reinitialized after digest");

endmodule

@@ sim/sha256_message_hasher_top_test.sv @@
module sha256_message_hasher_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_PERIOD  = 8;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          HOLD_CYCLES = 500;
	localparam int          PHASE_ITEMS = 140;
	localparam int          DRAIN_WAIT  = 300;
	localparam logic [7:0]  MARK_BYTE   = 8'h80;

	localparam sha_pkg::word_t START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam sha_pkg::word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		sha_pkg::word_t word;
		logic           last;
	} digest_item_t;

	// Running SHA-256 state plus the digest words still owed by the block
	class digest_board;
		sha_pkg::word_t hash_acc [8];
		sha_pkg::word_t block_buf [16];
		int unsigned    block_pos;
		logic [60:0]    byte_count;
		digest_item_t   pending_digest [$];
		int             errors;

		function new();
			errors = 0;
			foreach (block_buf[i])
				block_buf[i] = '0;
			restart();
		endfunction

		function void restart();
			foreach (hash_acc[i])
				hash_acc[i] = START_HASH[i];
			block_pos = 0;
			byte_count = '0;
		endfunction

		function sha_pkg::word_t ror(input sha_pkg::word_t x, input int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			sha_pkg::word_t sched [64];
			sha_pkg::word_t v [8];
			sha_pkg::word_t lo, hi, t1, t2;
			int             t;
			for (t = 0; t < 16; t++)
				sched[t] = block_buf[t];
			for (t = 16; t < 64; t++) begin
				lo = ror(sched[t-15], 7) ^ ror(sched[t-15], 18) ^ (sched[t-15] >> 3);
				hi = ror(sched[t-2], 17) ^ ror(sched[t-2], 19) ^ (sched[t-2] >> 10);
				sched[t] = hi + sched[t-7] + lo + sched[t-16];
			end
			for (t = 0; t < 8; t++)
				v[t] = hash_acc[t];
			for (t = 0; t < 64; t++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + sched[t];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (t = 0; t < 8; t++)
				hash_acc[t] += v[t];
		endfunction

		function void put_byte(input logic [7:0] b);
			block_buf[block_pos >> 2][(3 - (block_pos & 3)) * 8 +: 8] = b;
			block_pos++;
			if (block_pos == 64) begin
				compress();
				block_pos = 0;
			end
		endfunction

		function void absorb_item(input bit has_byte, input logic [7:0] b, input bit is_final);
			logic [63:0]  bit_len;
			digest_item_t owed;
			if (has_byte) begin
				put_byte(b);
				byte_count++;
			end
			if (!is_final)
				return;
			bit_len = {byte_count, 3'b000};
			put_byte(MARK_BYTE);
			// no room left for the length: close this block with zeros first
			if (block_pos > 56)
				while (block_pos != 0)
					put_byte(8'h00);
			while (block_pos < 56)
				put_byte(8'h00);
			for (int i = 0; i < 8; i++)
				put_byte(bit_len[63 - 8 * i -: 8]);
			for (int i = 0; i < 8; i++) begin
				owed.word = hash_acc[i];
				owed.last = (i == 7);
				pending_digest.insert(pending_digest.size(), owed);
			end
			restart();
		endfunction

		function void check_word(input sha_pkg::word_t word, input logic last);
			digest_item_t want;
			if (pending_digest.size() == 0) begin
				$error("digest item with none pending: digest_word=%h digest_last=%b",
					word, last);
				errors++;
				return;
			end
			want = pending_digest.pop_front();
			if (word !== want.word) begin
				$error("digest_word: expected %h, actual %h", want.word, word);
				errors++;
			end
			if (last !== want.last) begin
				$error("digest_last: expected %b, actual %b", want.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_digest.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	digest_board sb;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          items_sent;
	int          hold_requests;
	int          holds_served;
	int          cycle_count;

	sha256_message_hasher_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tlast);
	end

	// receiver: random back-pressure, plus long hold-offs on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(input bit has_byte, input logic [7:0] b, input bit is_final);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= has_byte;
		s_axis_tdata <= b;
		s_axis_tlast <= is_final;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.absorb_item(has_byte, b, is_final);
		items_sent++;
	endtask

	// byte-less items sprinkled in; the final item carries the last byte or none
	task automatic send_message(input int unsigned len, input bit byte_on_final);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				send_item(1'b0, 8'($urandom), 1'b0);
			send_item(1'b1, 8'($urandom), (i == len - 1) && byte_on_final);
		end
		if (len == 0 || !byte_on_final)
			send_item(1'b0, 8'($urandom), 1'b1);
	endtask

	// mostly short messages, some right at the padding boundaries, some long
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(0, 12);
		if (r < 85)
			case ($urandom_range(7))
				0: return 54;
				1: return 55;
				2: return 56;
				3: return 57;
				4: return 63;
				5: return 64;
				6: return 65;
				default: return 119;
			endcase
		return $urandom_range(0, 140);
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		items_sent = 0;
		hold_requests = 0;
		holds_served = 0;
		cycle_count = 0;
		sb = new();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 80;
		send_item(1'b0, 8'h00, 1'b1);             // empty message
		send_item(1'b1, 8'h00, 1'b1);
		send_item(1'b1, 8'hff, 1'b1);
		send_item(1'b1, 8'h61, 1'b0);             // "abc", with byte-less items in between
		send_item(1'b0, 8'hff, 1'b0);
		send_item(1'b1, 8'h62, 1'b0);
		send_item(1'b0, 8'h00, 1'b0);
		send_item(1'b1, 8'h63, 1'b0);
		send_item(1'b0, 8'h5a, 1'b1);             // empty final after data
		send_item(1'b0, 8'ha5, 1'b0);
		send_item(1'b1, 8'h80, 1'b0);
		send_item(1'b1, 8'h7f, 1'b0);
		send_item(1'b1, 8'haa, 1'b0);
		send_item(1'b1, 8'h55, 1'b1);
		send_item(1'b1, 8'h01, 1'b1);             // fresh state after a digest
		send_item(1'b0, 8'hfe, 1'b1);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 25; recv_idle_pct = 80; end
				1: begin send_idle_pct = 80; recv_idle_pct = 25; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			items_sent = 0;
			if (ph == 2) begin
				// stall the output while short messages keep coming
				hold_requests++;
				for (int m = 0; m < 4; m++)
					send_message($urandom_range(0, 6), 1'($urandom));
			end
			while (items_sent < PHASE_ITEMS)
				send_message(pick_length(), 1'($urandom));
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
design/sha_pkg.sv
design/sha256_message_hasher_top.sv
sim/sha256_message_hasher_top_test.sv
